/* src/nstg_pkg.sv */
// Shared types and constants of the nine-slice tile command generator.
package nstg_pkg;

    // Width of internal region sizes; covers the largest frame of the parameter range
    localparam int DIM_W = 10;

    // Widths of the stream payloads
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;

    // Region codes, in the order they are sent to the walker
    localparam logic [3:0] REGION_CENTER       = 4'd0;
    localparam logic [3:0] REGION_TOP          = 4'd1;
    localparam logic [3:0] REGION_BOTTOM       = 4'd2;
    localparam logic [3:0] REGION_LEFT         = 4'd3;
    localparam logic [3:0] REGION_RIGHT        = 4'd4;
    localparam logic [3:0] REGION_CORNER_TL    = 4'd5;
    localparam logic [3:0] REGION_CORNER_TR    = 4'd6;
    localparam logic [3:0] REGION_CORNER_BL    = 4'd7;
    localparam logic [3:0] REGION_CORNER_BR    = 4'd8;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_PUSH
    } front_state_t;

    // One region handed from the classifier to the walker
    typedef struct packed {
        logic [12:0]      src_x;
        logic [12:0]      src_y;
        logic [13:0]      dst_x;
        logic [13:0]      dst_y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             stretch;
        logic             last;
    } region_t;

endpackage

/* src/nine_slice_tile_command_generator.sv */
// Path: with the walker idle, an accepted request is held in the front end's registers,
// its non-empty regions pass the queue and the walker and are registered onto m_tdata.
// Throughput: one command per cycle while m_tready is high; a request yields 4 to 64
// commands with the default span, paced by the tile walker's single output register.
// The front end takes the next request after its nine regions; the walker drains the queue.
// Reset: aresetn low at a clock edge returns the front end to idle, empties the queue and
// the walker and drops any command in flight; nothing else needs clearing.
module nine_slice_tile_command_generator #(
    parameter int TILE_PIXELS    = 32,
    parameter int MAX_TILES_SPAN = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_column, start_line, rect_x, rect_y, rect_w, rect_h, zero pad
    input  logic [nstg_pkg::S_TDATA_W-1:0] s_tdata,
    // stretch_middle, stretch_edges
    input  logic [nstg_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h, zero pad
    output logic [nstg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import nstg_pkg::*;

    region_t push_data, pop_data;
    logic    push_valid, push_ready, pop_valid, pop_ready;

    nstg_front #(
        .TILE_PIXELS    (TILE_PIXELS),
        .MAX_TILES_SPAN (MAX_TILES_SPAN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_data   (push_data),
        .q_valid  (push_valid),
        .q_ready  (push_ready)
    );

    nstg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_data  (push_data),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .rd_data  (pop_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready)
    );

    nstg_back #(
        .TILE_PIXELS (TILE_PIXELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (pop_data),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/nstg_front.sv */
// Request front end: clamps the frame size and splits it into nine regions.
module nstg_front #(
    parameter int TILE_PIXELS    = 32,
    parameter int MAX_TILES_SPAN = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nstg_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [nstg_pkg::S_TUSER_W-1:0]    s_tuser,
    output nstg_pkg::region_t                 q_data,
    output logic                              q_valid,
    input  logic                              q_ready
);
    import nstg_pkg::*;

    localparam logic [DIM_W-1:0] SIZE_LO = DIM_W'(2 * TILE_PIXELS);
    localparam logic [DIM_W-1:0] SIZE_HI = DIM_W'(MAX_TILES_SPAN * TILE_PIXELS);
    localparam logic [DIM_W-1:0] TILE_D  = DIM_W'(TILE_PIXELS);
    localparam logic [12:0]      TILE_13 = 13'(TILE_PIXELS);
    localparam logic [13:0]      TILE_14 = 14'(TILE_PIXELS);

    front_state_t     state_reg, state_next;
    logic [3:0]       region_reg, region_next;
    logic [12:0]      sx_reg, sy_reg;
    logic [13:0]      x_reg, y_reg, xfar_reg, yfar_reg;
    logic [DIM_W-1:0] iw_reg, ih_reg;
    logic             sm_reg, se_reg;

    logic             accept;
    logic [DIM_W-1:0] w_in, h_in, w_clamp, h_clamp;
    logic [13:0]      x_in, y_in;
    logic             region_empty;
    logic             advance;
    region_t          region;

    assign accept = s_tvalid && s_tready;
    assign w_in   = DIM_W'(s_tdata[50:42]);
    assign h_in   = DIM_W'(s_tdata[59:51]);
    assign x_in   = {s_tdata[28], s_tdata[28:16]};
    assign y_in   = {s_tdata[41], s_tdata[41:29]};

    // Saturate the frame size to the supported span
    always_comb begin
        w_clamp = w_in;
        if (w_in < SIZE_LO) w_clamp = SIZE_LO;
        if (w_in > SIZE_HI) w_clamp = SIZE_HI;
        h_clamp = h_in;
        if (h_in < SIZE_LO) h_clamp = SIZE_LO;
        if (h_in > SIZE_HI) h_clamp = SIZE_HI;
    end

    // Hold the request in pixel form
    always_ff @(posedge aclk) begin
        if (accept) begin
            sx_reg   <= 13'(s_tdata[7:0]) * TILE_13;
            sy_reg   <= 13'(s_tdata[15:8]) * TILE_13;
            x_reg    <= x_in;
            y_reg    <= y_in;
            xfar_reg <= x_in + 14'(w_clamp) - TILE_14;
            yfar_reg <= y_in + 14'(h_clamp) - TILE_14;
            iw_reg   <= w_clamp - SIZE_LO;
            ih_reg   <= h_clamp - SIZE_LO;
            sm_reg   <= s_tuser[0];
            se_reg   <= s_tuser[1];
        end
    end

    // Build the descriptor of the current region
    always_comb begin
        region         = '0;
        region.stretch = se_reg;
        region.last    = 1'b0;
        region_empty   = 1'b0;
        case (region_reg)
            REGION_CENTER: begin
                region.src_x   = sx_reg + TILE_13;
                region.src_y   = sy_reg + TILE_13;
                region.dst_x   = x_reg + TILE_14;
                region.dst_y   = y_reg + TILE_14;
                region.w       = iw_reg;
                region.h       = ih_reg;
                region.stretch = sm_reg;
                region_empty   = (iw_reg == '0) || (ih_reg == '0);
            end
            REGION_TOP: begin
                region.src_x = sx_reg + TILE_13;
                region.src_y = sy_reg;
                region.dst_x = x_reg + TILE_14;
                region.dst_y = y_reg;
                region.w     = iw_reg;
                region.h     = TILE_D;
                region_empty = (iw_reg == '0);
            end
            REGION_BOTTOM: begin
                region.src_x = sx_reg + TILE_13;
                region.src_y = sy_reg + (TILE_13 << 1);
                region.dst_x = x_reg + TILE_14;
                region.dst_y = yfar_reg;
                region.w     = iw_reg;
                region.h     = TILE_D;
                region_empty = (iw_reg == '0);
            end
            REGION_LEFT: begin
                region.src_x = sx_reg;
                region.src_y = sy_reg + TILE_13;
                region.dst_x = x_reg;
                region.dst_y = y_reg + TILE_14;
                region.w     = TILE_D;
                region.h     = ih_reg;
                region_empty = (ih_reg == '0);
            end
            REGION_RIGHT: begin
                region.src_x = sx_reg + (TILE_13 << 1);
                region.src_y = sy_reg + TILE_13;
                region.dst_x = xfar_reg;
                region.dst_y = y_reg + TILE_14;
                region.w     = TILE_D;
                region.h     = ih_reg;
                region_empty = (ih_reg == '0);
            end
            REGION_CORNER_TL: begin
                region.src_x   = sx_reg;
                region.src_y   = sy_reg;
                region.dst_x   = x_reg;
                region.dst_y   = y_reg;
                region.w       = TILE_D;
                region.h       = TILE_D;
                region.stretch = 1'b1;
            end
            REGION_CORNER_TR: begin
                region.src_x   = sx_reg + (TILE_13 << 1);
                region.src_y   = sy_reg;
                region.dst_x   = xfar_reg;
                region.dst_y   = y_reg;
                region.w       = TILE_D;
                region.h       = TILE_D;
                region.stretch = 1'b1;
            end
            REGION_CORNER_BL: begin
                region.src_x   = sx_reg;
                region.src_y   = sy_reg + (TILE_13 << 1);
                region.dst_x   = x_reg;
                region.dst_y   = yfar_reg;
                region.w       = TILE_D;
                region.h       = TILE_D;
                region.stretch = 1'b1;
            end
            REGION_CORNER_BR: begin
                region.src_x   = sx_reg + (TILE_13 << 1);
                region.src_y   = sy_reg + (TILE_13 << 1);
                region.dst_x   = xfar_reg;
                region.dst_y   = yfar_reg;
                region.w       = TILE_D;
                region.h       = TILE_D;
                region.stretch = 1'b1;
                region.last    = 1'b1;
            end
            default: begin
                region_empty = 1'b1;
            end
        endcase
    end

    assign advance = (state_reg == FRONT_PUSH) && (region_empty || q_ready);

    // Next state: idle until a request, then one region per cycle unless a non-empty region waits on a full queue
    always_comb begin
        state_next  = state_reg;
        region_next = region_reg;
        case (state_reg)
            FRONT_IDLE: begin
                if (accept) begin
                    state_next  = FRONT_PUSH;
                    region_next = REGION_CENTER;
                end
            end
            FRONT_PUSH: begin
                if (advance) begin
                    if (region_reg == REGION_CORNER_BR) begin
                        state_next = FRONT_IDLE;
                    end else begin
                        region_next = region_reg + 4'd1;
                    end
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // Outputs: take requests when idle, push non-empty regions
    always_comb begin
        s_tready = 1'b0;
        q_valid  = 1'b0;
        case (state_reg)
            FRONT_IDLE: s_tready = 1'b1;
            FRONT_PUSH: q_valid  = !region_empty;
            default:    s_tready = 1'b0;
        endcase
    end

    assign q_data = region;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FRONT_IDLE;
            region_reg <= REGION_CENTER;
        end else begin
            state_reg  <= state_next;
            region_reg <= region_next;
        end
    end

endmodule

/* src/nstg_queue.sv */
// Short region queue between the front end and the tile walker.
module nstg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  nstg_pkg::region_t wr_data,
    input  logic              wr_valid,
    output logic              wr_ready,
    output nstg_pkg::region_t rd_data,
    output logic              rd_valid,
    input  logic              rd_ready
);
    import nstg_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    region_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    // Store the incoming region
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* src/nstg_back.sv */
// Tile walker: turns each region into blit commands, one per cycle unless m_tready holds the output register.
module nstg_back #(
    parameter int TILE_PIXELS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  nstg_pkg::region_t              q_data,
    input  logic                           q_valid,
    output logic                           q_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nstg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import nstg_pkg::*;

    localparam logic [DIM_W-1:0] TILE_D = DIM_W'(TILE_PIXELS);

    region_t          cur_reg;
    logic             active_reg;
    logic [DIM_W-1:0] cx_reg, cy_reg;

    logic             m_valid_reg;
    logic [12:0]      src_x_reg, src_y_reg;
    logic [5:0]       src_w_reg, src_h_reg;
    logic [13:0]      dst_x_reg, dst_y_reg;
    logic [7:0]       dst_w_reg, dst_h_reg;
    logic             last_reg;

    logic             emit, done, row_end, col_end;
    logic [DIM_W-1:0] rem_w, rem_h, cw, ch;
    logic [DIM_W:0]   cx_sum, cy_sum;

    assign emit = active_reg && (!m_valid_reg || m_tready);

    // Clip the tile to what is left of the region
    always_comb begin
        rem_w   = cur_reg.w - cx_reg;
        rem_h   = cur_reg.h - cy_reg;
        cw      = (rem_w > TILE_D) ? TILE_D : rem_w;
        ch      = (rem_h > TILE_D) ? TILE_D : rem_h;
        cx_sum  = {1'b0, cx_reg} + {1'b0, TILE_D};
        cy_sum  = {1'b0, cy_reg} + {1'b0, TILE_D};
        row_end = (cy_sum >= {1'b0, cur_reg.h});
        col_end = (cx_sum >= {1'b0, cur_reg.w});
        done    = cur_reg.stretch || (row_end && col_end);
    end

    assign q_ready = !active_reg || (emit && done);

    // Walk column-major; load the next region as the current one finishes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
        end else begin
            if (q_ready) begin
                active_reg <= q_valid;
                cx_reg     <= '0;
                cy_reg     <= '0;
            end else if (emit) begin
                if (row_end) begin
                    cy_reg <= '0;
                    cx_reg <= cx_sum[DIM_W-1:0];
                end else begin
                    cy_reg <= cy_sum[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            cur_reg <= q_data;
        end
    end

    // Output register: hold the command until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            src_x_reg <= cur_reg.src_x;
            src_y_reg <= cur_reg.src_y;
            last_reg  <= cur_reg.last && done;
            if (cur_reg.stretch) begin
                src_w_reg <= 6'(TILE_PIXELS);
                src_h_reg <= 6'(TILE_PIXELS);
                dst_x_reg <= cur_reg.dst_x;
                dst_y_reg <= cur_reg.dst_y;
                dst_w_reg <= cur_reg.w[7:0];
                dst_h_reg <= cur_reg.h[7:0];
            end else begin
                src_w_reg <= cw[5:0];
                src_h_reg <= ch[5:0];
                dst_x_reg <= cur_reg.dst_x + 14'(cx_reg);
                dst_y_reg <= cur_reg.dst_y + 14'(cy_reg);
                dst_w_reg <= cw[7:0];
                dst_h_reg <= ch[7:0];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'b0, dst_h_reg, dst_w_reg, dst_y_reg, dst_x_reg,
                       src_h_reg, src_w_reg, src_y_reg, src_x_reg};

endmodule
